// ----- design/signed_int_list_parser_top_assert.svh -----
// Assertion macros shared by the parser RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
// Keep commas out of the expression arguments.
`ifndef SIGNED_INT_LIST_PARSER_TOP_ASSERT_SVH
`define SIGNED_INT_LIST_PARSER_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SIL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SIL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition holds at every edge out of reset.
`define SIL_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- design/sil_pkg.sv -----
`default_nettype none
package sil_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADCHAR  = 3'd1,
    ST_NODIGITS = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOWORDS  = 3'd4
  } status_t;

  localparam logic [7:0]  CH_MINUS   = 8'h2D;
  localparam logic [7:0]  CH_PLUS    = 8'h2B;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_NINE    = 8'h39;
  localparam logic [7:0]  DELIM_RST  = 8'd32;
  localparam logic [31:0] POS_LIMIT  = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT  = 32'h8000_0000;

  // One result as it waits in the output queue.
  typedef struct packed {
    logic signed [31:0] number;
    logic               is_status;
    status_t            status;
    logic               run_end;
  } res_t;

endpackage
`default_nettype wire

// ----- design/sil_res_fifo.sv -----
`default_nettype none
module sil_res_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push0,
  input  wire sil_pkg::res_t push0_data,
  input  wire logic          push1,
  input  wire sil_pkg::res_t push1_data,
  output logic               room2,
  output logic               head_valid,
  output sil_pkg::res_t      head_data,
  input  wire logic          pop
);
  import sil_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r   [DEPTH];
  res_t          mem_nxt [DEPTH];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] base;
  logic          pop_ok;

  assign pop_ok     = pop && (count_r != '0);
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[0];
  assign room2      = (count_r <= CW'(DEPTH - 2));
  assign base       = count_r - CW'(pop_ok);

  // Entries shift toward the head on a pop; new results land behind the survivors.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop_ok && (i + 1 < DEPTH)) begin
        mem_nxt[i] = mem_r[(i + 1) % DEPTH];
      end else begin
        mem_nxt[i] = mem_r[i];
      end
      if (push0 && (base == CW'(i))) begin
        mem_nxt[i] = push0_data;
      end
      if (push1 && (base + CW'(1) == CW'(i))) begin
        mem_nxt[i] = push1_data;
      end
    end
    count_nxt = base + CW'(push0) + CW'(push1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      mem_r[i] <= mem_nxt[i];
    end
  end

`include "signed_int_list_parser_top_assert.svh"
  `SIL_ASSERT_ALW(a_count_bound, count_r <= CW'(DEPTH), "result queue count beyond depth")
  `SIL_ASSERT_IMP(a_no_overflow, push0 && !room2, 1'b0, "push while result queue is full")

endmodule
`default_nettype wire

// ----- design/signed_int_list_parser_top.sv -----
`default_nettype none
// Channel   Direction  Ports                    Contents
// in_       slave      tvalid tready tdata tlast text byte, end of text on tlast
// out_      master     tvalid tready tdata tuser tlast  number, status, kind, run_end flag
// cfg_      write      wr_en wr_data            delimiter byte
//
// One text byte is accepted per cycle while in_tready is high; its results are
// registered into the result queue, so out_tvalid follows in the cycle after the request.
// A byte gives zero, one or two results; two only on the final byte of a text,
// and those leave the output one after the other.
// in_tready depends only on the queue fill: it stays high while two free slots remain.
// Reset (synchronous, active low) empties the queue, clears all word state and
// sets the delimiter to 32 (space).
// A stalled output keeps its result on out_tdata until taken.
module signed_int_list_parser_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input requests.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_text
  // Result requests.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] number, [34:32] status, [39:35] zero
  output logic             out_tuser,  // is_status
  output logic             out_tlast,  // run_end
  // Delimiter register write.
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);
  import sil_pkg::*;

  logic [7:0]  delimiter_r;
  logic        inside_word_r,   inside_word_nxt;
  logic        negative_sign_r, negative_sign_nxt;
  logic        sign_taken_r,    sign_taken_nxt;
  logic        digit_taken_r,   digit_taken_nxt;
  logic [31:0] magnitude_r,     magnitude_nxt;
  logic        word_found_r,    word_found_nxt;
  status_t     first_error_r,   first_error_nxt;

  logic        accept;
  logic        is_delim;
  logic        is_digit;
  logic        is_sign;
  logic [35:0] prod;
  logic [31:0] mag_sat;
  // Word state after the byte itself has been handled.
  logic        iw1, neg1, st1, dt1, wf1;
  logic [31:0] mag1;
  status_t     fe1, fe2;
  logic        finish;
  logic        val_push;
  status_t     final_status;
  res_t        val_res, stat_res;
  logic        push0, push1;
  res_t        push0_data, push1_data;
  res_t        head;

  assign accept   = in_tvalid && in_tready;
  assign is_delim = (in_tdata != 8'd0) && (in_tdata == delimiter_r);
  assign is_digit = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign is_sign  = (in_tdata == CH_MINUS) || (in_tdata == CH_PLUS);

  // Times ten plus digit; a carry past 32 bits saturates the magnitude.
  assign prod    = {1'b0, magnitude_r, 3'b000} + {3'b000, magnitude_r, 1'b0}
                 + {32'd0, in_tdata[3:0]};
  assign mag_sat = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];

  always_comb begin
    iw1  = inside_word_r;
    neg1 = negative_sign_r;
    st1  = sign_taken_r;
    dt1  = digit_taken_r;
    mag1 = magnitude_r;
    wf1  = word_found_r;
    fe1  = first_error_r;
    if (!is_delim) begin
      iw1 = 1'b1;
      wf1 = 1'b1;
      if (is_digit) begin
        mag1 = mag_sat;
        dt1  = 1'b1;
      end else if (is_sign && !inside_word_r) begin
        st1  = 1'b1;
        neg1 = (in_tdata == CH_MINUS);
      end else if (first_error_r == ST_OK) begin
        fe1 = ST_BADCHAR;
      end
    end

    // A delimiter or the final byte closes any open word.
    finish   = (is_delim || in_tlast) && iw1;
    fe2      = fe1;
    val_push = 1'b0;
    if (finish) begin
      if (!dt1) begin
        if (fe1 == ST_OK) fe2 = ST_NODIGITS;
      end else if (neg1 ? (mag1 > NEG_LIMIT) : (mag1 > POS_LIMIT)) begin
        if (fe1 == ST_OK) fe2 = ST_RANGE;
      end else if (fe1 == ST_OK) begin
        val_push = 1'b1;
      end
    end

    if (fe2 != ST_OK) begin
      final_status = fe2;
    end else if (!wf1) begin
      final_status = ST_NOWORDS;
    end else begin
      final_status = ST_OK;
    end

    val_res.number    = neg1 ? $signed(32'd0 - mag1) : $signed(mag1);
    val_res.is_status = 1'b0;
    val_res.status    = ST_OK;
    val_res.run_end   = !in_tlast;

    stat_res.number    = 32'sd0;
    stat_res.is_status = 1'b1;
    stat_res.status    = final_status;
    stat_res.run_end   = 1'b1;

    // Pack results into the queue in order: value first, status behind it.
    push0      = accept && (val_push || in_tlast);
    push1      = accept && val_push && in_tlast;
    push0_data = val_push ? val_res : stat_res;
    push1_data = stat_res;

    if (in_tlast || finish) begin
      inside_word_nxt   = 1'b0;
      negative_sign_nxt = 1'b0;
      sign_taken_nxt    = 1'b0;
      digit_taken_nxt   = 1'b0;
      magnitude_nxt     = 32'd0;
    end else begin
      inside_word_nxt   = iw1;
      negative_sign_nxt = neg1;
      sign_taken_nxt    = st1;
      digit_taken_nxt   = dt1;
      magnitude_nxt     = mag1;
    end
    word_found_nxt  = in_tlast ? 1'b0  : wf1;
    first_error_nxt = in_tlast ? ST_OK : fe2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r     <= DELIM_RST;
      inside_word_r   <= 1'b0;
      negative_sign_r <= 1'b0;
      sign_taken_r    <= 1'b0;
      digit_taken_r   <= 1'b0;
      magnitude_r     <= 32'd0;
      word_found_r    <= 1'b0;
      first_error_r   <= ST_OK;
    end else begin
      if (cfg_wr_en) begin
        delimiter_r <= cfg_wr_data;
      end
      if (accept) begin
        inside_word_r   <= inside_word_nxt;
        negative_sign_r <= negative_sign_nxt;
        sign_taken_r    <= sign_taken_nxt;
        digit_taken_r   <= digit_taken_nxt;
        magnitude_r     <= magnitude_nxt;
        word_found_r    <= word_found_nxt;
        first_error_r   <= first_error_nxt;
      end
    end
  end

  sil_res_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (push0),
    .push0_data (push0_data),
    .push1      (push1),
    .push1_data (push1_data),
    .room2      (in_tready),
    .head_valid (out_tvalid),
    .head_data  (head),
    .pop        (out_tready)
  );

  assign out_tdata = {5'd0, head.status, head.number};
  assign out_tuser = head.is_status;
  assign out_tlast = head.run_end;

`include "signed_int_list_parser_top_assert.svh"
  `SIL_ASSERT_NXT(a_text_end_clears, accept && in_tlast,
    !inside_word_r && !word_found_r && (first_error_r == ST_OK),
    "state not cleared after end of text")
  `SIL_ASSERT_IMP(a_two_only_at_end, push1, push0 && in_tlast,
    "two results from a byte that does not end the text")
  `SIL_ASSERT_IMP(a_no_value_after_error, accept && (first_error_r != ST_OK), !val_push,
    "value result emitted after an error")

endmodule
`default_nettype wire
